// ===== hw/rtl/bod_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bod_pkg
// Shared types, command and status codes and stream layout for the bounded
// ordered deque.
// ----------------------------------------------------------------------------
package bod_pkg;

  // default storage depth of the list
  localparam int STORE_DEPTH_DEF = 16;

  // field widths
  localparam int CAP_W    = 5;
  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // capacity limit after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;

  // input tdata layout: cmd, target, value from the lowest bit up
  localparam int CMD_LSB     = 0;
  localparam int TARGET_LSB  = CMD_LSB + CMD_W;
  localparam int VALUE_LSB   = TARGET_LSB + DATA_W;
  localparam int IN_FIELDS_W = VALUE_LSB + DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // output tdata layout: status, occupancy from the lowest bit up
  localparam int STATUS_LSB   = 0;
  localparam int OCC_LSB      = STATUS_LSB + STATUS_W;
  localparam int OUT_FIELDS_W = OCC_LSB + OCC_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } bod_resp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bod_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bod_mem
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bod_mem #(
  parameter int STORE_DEPTH = bod_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [bod_pkg::DATA_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [bod_pkg::DATA_W-1:0] rdata
);
  import bod_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bod_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bod_ctrl
// Command sequencer: keeps head and count of a circular list in the entry
// store, searches for the anchor and shifts the tail to open a gap.
// ----------------------------------------------------------------------------
module bod_ctrl #(
  parameter int STORE_DEPTH = bod_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // command in
  input  wire logic                        start,
  input  wire logic [bod_pkg::CMD_W-1:0]   cmd,
  input  wire logic [bod_pkg::DATA_W-1:0]  target,
  input  wire logic [bod_pkg::DATA_W-1:0]  value,
  input  wire logic [bod_pkg::CAP_W-1:0]   cap,
  output logic                             idle,
  // result out
  output bod_pkg::bod_resp_t               resp,
  input  wire logic                        resp_take,
  // entry store
  output logic                             mem_we,
  output logic      [AW-1:0]               mem_waddr,
  output logic      [bod_pkg::DATA_W-1:0]  mem_wdata,
  output logic                             mem_re,
  output logic      [AW-1:0]               mem_raddr,
  input  wire logic [bod_pkg::DATA_W-1:0]  mem_rdata
);
  import bod_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;
  localparam int EW = CW + OCC_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(STORE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(STORE_DEPTH - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0]          state_r,  state_nxt;
  logic [CW-1:0]       count_r,  count_nxt;
  logic [AW-1:0]       head_r,   head_nxt;
  logic [CW-1:0]       idx_r,    idx_nxt;
  logic [CW-1:0]       pos_r,    pos_nxt;
  logic                rd_v_r,   rd_v_nxt;
  logic [CW-1:0]       rd_tag_r, rd_tag_nxt;
  logic [CMD_W-1:0]    cmd_r,    cmd_nxt;
  logic [DATA_W-1:0]   target_r, target_nxt;
  logic [DATA_W-1:0]   value_r,  value_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                full;
  logic                empty;
  logic                hit;
  logic                issue;
  logic [EW-1:0]       occ_ext;

  // list position to store address, head plus offset wrapped at the depth
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] lidx);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(lidx);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  // capacity is the smaller of the limit and the store depth
  assign full  = (MW'(count_r) >= MW'(cap)) || (count_r >= DEPTH_C);
  assign empty = (count_r == '0);
  assign hit   = rd_v_r && (mem_rdata == target_r);
  assign idle  = (state_r == S_IDLE);

  // result toward the output stage
  assign occ_ext        = EW'(count_r);
  assign resp.valid     = (state_r == S_RESP);
  assign resp.status    = status_r;
  assign resp.occupancy = occ_ext[OCC_W-1:0];

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    rd_v_nxt   = 1'b0;
    rd_tag_nxt = rd_tag_r;
    cmd_nxt    = cmd_r;
    target_nxt = target_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = head_r;
    mem_wdata  = value_r;
    mem_re     = 1'b0;
    mem_raddr  = head_r;
    issue      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = cmd;
          target_nxt = target;
          value_nxt  = value;
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
          case (cmd)
            CMD_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                head_nxt  = (head_r == '0) ? LAST_A : head_r - AW'(1);
                mem_we    = 1'b1;
                mem_waddr = head_nxt;
                mem_wdata = value;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = phys_addr(head_r, count_r);
                mem_wdata = value;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                head_nxt  = (head_r == LAST_A) ? '0 : head_r + AW'(1);
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        // one read a cycle from the front, compare as data returns
        issue = (idx_r < count_r) && !hit;
        if (issue) begin
          mem_re     = 1'b1;
          mem_raddr  = phys_addr(head_r, idx_r);
          idx_nxt    = idx_r + CW'(1);
          rd_tag_nxt = idx_r;
          rd_v_nxt   = 1'b1;
        end
        if (hit) begin
          pos_nxt   = rd_tag_r + CW'(cmd_r == CMD_INS_AFTER);
          idx_nxt   = count_r;
          state_nxt = S_SHIFT;
        end else if (rd_v_r && (rd_tag_r == count_r - CW'(1))) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end
      end
      S_SHIFT: begin
        // move entry j-1 to j from the tail down, each write using the registered read data
        if (rd_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = phys_addr(head_r, rd_tag_r);
          mem_wdata = mem_rdata;
        end
        if (idx_r != pos_r) begin
          mem_re     = 1'b1;
          mem_raddr  = phys_addr(head_r, idx_r - CW'(1));
          rd_tag_nxt = idx_r;
          idx_nxt    = idx_r - CW'(1);
          rd_v_nxt   = 1'b1;
        end else if (!rd_v_r) begin
          // gap is open, place the new value
          mem_we     = 1'b1;
          mem_waddr  = phys_addr(head_r, pos_r);
          mem_wdata  = value_r;
          count_nxt  = count_r + CW'(1);
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (resp_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      head_r  <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      rd_v_r  <= rd_v_nxt;
    end
  end

  // working registers of the current command
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    rd_tag_r <= rd_tag_nxt;
    cmd_r    <= cmd_nxt;
    target_r <= target_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_ordered_deque.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_ordered_deque
// Ordered list of signed 32-bit values with push and pop at both ends and
// insert before or after the first entry equal to a target.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one command per item (cmd, target, value in in_tdata).
//   out_*  : one result per command (status, occupancy after the command).
//   cfg_*  : capacity limit, written while the block is idle.
// Timing:
//   A push or pop is done on acceptance; its result passes through the
//   sequencer's result state and then the output register before it shows
//   on out_tvalid. An insert first searches, reading one stored entry a
//   cycle until the target is found or the list ends, then moves the tail
//   one entry a cycle through the single write port of the entry store,
//   then places the value.
//   One command is worked on at a time; the next one is taken as soon as the
//   result has moved into the output register, even if it is still waiting.
// Reset:
//   The list empties, the capacity limit returns to 4, no result pending.
// Stall:
//   A held result stays on out_tdata; a second finished result waits in the
//   sequencer and no new item is taken until the output register frees up.
// ----------------------------------------------------------------------------
module bounded_ordered_deque #(
  parameter int STORE_DEPTH = bod_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // cmd[2:0], target[34:3], value[66:35], zero fill
  input  wire logic [bod_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status[1:0], occupancy[6:2], zero fill
  output logic      [bod_pkg::OUT_TDATA_W-1:0] out_tdata,
  // capacity limit
  input  wire logic                            cfg_wr_en,
  input  wire logic [bod_pkg::CAP_W-1:0]       cfg_wr_data
);
  import bod_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic [CAP_W-1:0]    cap_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [OCC_W-1:0]    out_occ_r;
  logic                ctrl_idle;
  logic                start;
  logic                resp_take;
  bod_resp_t           resp;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  // input handshake
  assign in_tready = ctrl_idle && rst_n;
  assign start     = in_tvalid && in_tready;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // output register, refilled whenever empty or being taken
  assign resp_take = resp.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_take) begin
      out_status_r <= resp.status;
      out_occ_r    <= resp.occupancy;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_occ_r, out_status_r};

  // sequencer
  bod_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (in_tdata[CMD_LSB +: CMD_W]),
    .target    (in_tdata[TARGET_LSB +: DATA_W]),
    .value     (in_tdata[VALUE_LSB +: DATA_W]),
    .cap       (cap_r),
    .idle      (ctrl_idle),
    .resp      (resp),
    .resp_take (resp_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // entry store
  bod_mem #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/bod_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bod_checker
// Port-level checks of the bounded ordered deque, bound to the top level.
// ----------------------------------------------------------------------------
module bod_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [bod_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bod_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty report comes only from an empty list
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STATUS_LSB +: STATUS_W] == ST_EMPTY)
    |-> (out_tdata[OCC_LSB +: OCC_W] == '0))
    else $error("empty status with nonzero occupancy");

  // one command at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while a command is in progress");

endmodule

bind bounded_ordered_deque bod_checker u_bod_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== dv/bounded_ordered_deque_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_deque_tb
// Self-checking bench for the bounded ordered deque. A queue-fed driver sends
// commands in random bursts and a monitor compares every result with a
// behavioral copy of the list. The run steps through several capacity limits
// and uses a value pool so inserts often find their target.
// ----------------------------------------------------------------------------
module bounded_ordered_deque_tb;
  import bod_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int DEPTH          = STORE_DEPTH_DEF;
  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 160;
  localparam int NUM_PHASES     = 10;

  // command codes the block treats as no operation
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] value;
  } deque_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } deque_result_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0]       cfg_wr_data = '0;

  // shadow of the list and the capacity register
  logic [DATA_W-1:0] shadow_list[$];
  logic [CAP_W-1:0]  shadow_cap = CAP_RESET;

  deque_cmd_t    cmd_backlog[$];
  deque_result_t expected_results[$];
  deque_cmd_t    cmd_in_flight;

  int err_count    = 0;
  int items_issued = 0;
  int results_seen = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int idle_cycles  = 0;

  logic [15:0] ready_mask = 16'hffff;
  int          mask_left  = 0;
  int          mask_bit   = 0;

  logic [DATA_W-1:0] key_pool[8];
  bit                fill_mode = 1'b1;
  int                mode_left = 0;

  bounded_ordered_deque #(
    .STORE_DEPTH (DEPTH)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // apply one command to the shadow list and return its status and count
  function automatic deque_result_t deque_apply(deque_cmd_t c);
    deque_result_t r;
    int            cap;
    int            pos;
    bit            is_full;
    r.status = ST_OK;
    cap = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    is_full = shadow_list.size() >= cap;
    case (c.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (is_full) r.status = ST_FULL;
        else if (c.cmd == CMD_PUSH_FRONT) shadow_list.push_front(c.value);
        else shadow_list.push_back(c.value);
      end
      CMD_POP_FRONT: begin
        if (shadow_list.size() == 0) r.status = ST_EMPTY;
        else void'(shadow_list.pop_front());
      end
      CMD_POP_BACK: begin
        if (shadow_list.size() == 0) r.status = ST_EMPTY;
        else void'(shadow_list.pop_back());
      end
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        if (shadow_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (is_full) begin
          r.status = ST_FULL;
        end else begin
          // first match searched from the front
          pos = -1;
          for (int i = 0; i < shadow_list.size(); i++)
            if (pos < 0 && shadow_list[i] == c.target) pos = i;
          if (pos < 0) r.status = ST_NOT_FOUND;
          else shadow_list.insert((c.cmd == CMD_INS_AFTER) ? pos + 1 : pos, c.value);
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(shadow_list.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] target,
                         input logic [DATA_W-1:0] value);
    deque_cmd_t c;
    c.cmd    = cmd;
    c.target = target;
    c.value  = value;
    cmd_backlog.push_back(c);
    items_issued++;
  endtask

  // extremes plus a few random keys, so inserts hit their target often
  task automatic refresh_pool();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
  endtask

  function automatic logic [DATA_W-1:0] pick_key(input int raw_pct);
    if ($urandom_range(0, 99) < raw_pct) return $urandom;
    return key_pool[$urandom_range(0, 7)];
  endfunction

  // runs that mostly grow the list alternate with runs that mostly shrink it
  task automatic add_random(input int n);
    int                r;
    logic [CMD_W-1:0]  cmd;
    for (int k = 0; k < n; k++) begin
      if (mode_left == 0) begin
        fill_mode = ~fill_mode;
        mode_left = $urandom_range(8, 40);
      end
      mode_left--;
      r = $urandom_range(0, 99);
      if (r < 3) cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
      else if (fill_mode) begin
        if (r < 30) cmd = CMD_PUSH_FRONT;
        else if (r < 55) cmd = CMD_PUSH_BACK;
        else if (r < 75) cmd = CMD_INS_AFTER;
        else if (r < 90) cmd = CMD_INS_BEFORE;
        else if (r < 95) cmd = CMD_POP_FRONT;
        else cmd = CMD_POP_BACK;
      end else begin
        if (r < 8) cmd = CMD_PUSH_FRONT;
        else if (r < 13) cmd = CMD_PUSH_BACK;
        else if (r < 23) cmd = CMD_INS_AFTER;
        else if (r < 33) cmd = CMD_INS_BEFORE;
        else if (r < 66) cmd = CMD_POP_FRONT;
        else cmd = CMD_POP_BACK;
      end
      add_cmd(cmd, pick_key(20), pick_key(15));
    end
  endtask

  // sender holds off until every result is back
  task automatic wait_drained();
    while (results_seen < items_issued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_cap = cap;
  endtask

  // command driver: bursts of random length with random gaps
  always @(posedge clk) begin : cmd_driver
    deque_cmd_t            nxt;
    logic [IN_TDATA_W-1:0] word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(deque_apply(cmd_in_flight));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          nxt = cmd_backlog.pop_front();
          cmd_in_flight = nxt;
          word = '0;
          word[CMD_LSB +: CMD_W]     = nxt.cmd;
          word[TARGET_LSB +: DATA_W] = nxt.target;
          word[VALUE_LSB +: DATA_W]  = nxt.value;
          in_tdata  <= word;
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result ready follows a 16-bit mask, stepped through bit by bit, that changes now and then
  always @(posedge clk) begin : result_stall
    if (mask_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_mask = 16'hffff;
        1: ready_mask = 16'($urandom) | 16'h0001;
        2: ready_mask = 16'($urandom & $urandom) | 16'h0001;
        default: ready_mask = 16'h0001;
      endcase
      mask_left = $urandom_range(16, 128);
    end else begin
      mask_left = mask_left - 1;
    end
    out_tready <= ready_mask[mask_bit];
    mask_bit = (mask_bit + 1) % 16;
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no command outstanding",
                        int'(out_tdata[OUT_FIELDS_W-1:0]), -1);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[STATUS_LSB +: STATUS_W] !== want.status)
          report_mismatch("status", int'(out_tdata[STATUS_LSB +: STATUS_W]),
                          int'(want.status));
        if (out_tdata[OCC_LSB +: OCC_W] !== want.occupancy)
          report_mismatch("occupancy", int'(out_tdata[OCC_LSB +: OCC_W]),
                          int'(want.occupancy));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps[NUM_PHASES];
    phase_caps = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd17, 5'd9, 5'd16, 5'd5, 5'd3};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset capacity of four
    add_cmd(CMD_POP_FRONT,  32'h0, 32'h0);                 // pop on empty
    add_cmd(CMD_POP_BACK,   32'h0, 32'h0);
    add_cmd(CMD_INS_AFTER,  32'h0, 32'h1);                 // insert on empty
    add_cmd(CMD_INS_BEFORE, 32'h0, 32'h1);
    add_cmd(CMD_RSVD_6,     32'hffff_ffff, 32'hffff_ffff);
    add_cmd(CMD_PUSH_BACK,  32'h0, 32'h7fff_ffff);
    add_cmd(CMD_PUSH_FRONT, 32'h0, 32'h8000_0000);
    add_cmd(CMD_INS_AFTER,  32'h7fff_ffff, 32'h0);         // after the tail
    add_cmd(CMD_INS_BEFORE, 32'h8000_0000, 32'hffff_ffff); // before the front
    add_cmd(CMD_PUSH_BACK,  32'h0, 32'h1);                 // full
    add_cmd(CMD_INS_AFTER,  32'h1234_5678, 32'h2);         // full wins over search
    add_cmd(CMD_PUSH_FRONT, 32'h0, 32'h3);
    add_cmd(CMD_POP_BACK,   32'h0, 32'h0);
    add_cmd(CMD_INS_BEFORE, 32'h5a5a_5a5a, 32'h4);         // target absent
    add_cmd(CMD_INS_AFTER,  32'h0, 32'ha5a5_a5a5);
    add_cmd(CMD_RSVD_7,     32'h0, 32'h0);
    add_cmd(CMD_POP_FRONT,  32'h0, 32'h0);
    add_cmd(CMD_INS_BEFORE, 32'h7fff_ffff, 32'h0);
    add_cmd(CMD_POP_BACK,   32'h0, 32'h0);
    add_cmd(CMD_INS_AFTER,  32'h0, 32'h1);                 // single match, at the tail
    repeat (4) add_cmd(CMD_POP_FRONT, 32'h0, 32'h0);
    add_cmd(CMD_POP_BACK,   32'h0, 32'h0);
    wait_drained();

    // random phases, each at its own capacity; list carries over between them
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      refresh_pool();
      add_random(PHASE_ITEMS / 2);
      wait_drained();
      add_random(PHASE_ITEMS / 2);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
